### rtl/ttaf_pkg.sv
// Shared types and constants for the top-two argmax finder.
// No dependencies; used by every module under rtl/.
package ttaf_pkg;

  localparam int VECTOR_SIZE_DEF = 256;
  localparam int LANES_DEF       = 8;
  localparam int VALUE_WIDTH_DEF = 12;
  localparam int INDEX_WIDTH     = 8;
  localparam int PORT_LANES      = 8;

  // entries held by a top-two record: none, one, or two and more
  typedef logic [1:0] cnt_t;
  localparam cnt_t CNT_NONE = 2'd0;
  localparam cnt_t CNT_ONE  = 2'd1;
  localparam cnt_t CNT_TWO  = 2'd2;

endpackage

### rtl/ttaf_lane.sv
// Per-lane index generation and range check for one entry of a beat.
// Depends on ttaf_pkg.
module ttaf_lane import ttaf_pkg::*; #(
  parameter int VECTOR_SIZE = VECTOR_SIZE_DEF,
  parameter int LANES       = LANES_DEF,
  parameter int LANE        = 0
) (
  input  logic [$clog2((VECTOR_SIZE + LANES - 1) / LANES + 1)-1:0] beat_num,
  output logic                                                     hit,
  output logic [INDEX_WIDTH-1:0]                                   index
);

  localparam int BEAT_LIMIT = (VECTOR_SIZE + LANES - 1) / LANES;
  localparam int BEAT_W     = $clog2(BEAT_LIMIT + 1);
  localparam int RAW_W      = $clog2((BEAT_LIMIT + 1) * LANES);
  localparam int IDXF_W     = (RAW_W > INDEX_WIDTH) ? RAW_W : INDEX_WIDTH;

  logic [IDXF_W-1:0] idx_full;

  assign idx_full = IDXF_W'(beat_num) * IDXF_W'(LANES) + IDXF_W'(LANE);
  assign hit      = (beat_num < BEAT_W'(BEAT_LIMIT)) && (idx_full < IDXF_W'(VECTOR_SIZE));
  assign index    = idx_full[INDEX_WIDTH-1:0];

endmodule

### rtl/ttaf_merge.sv
// Merges two top-two records; b holds the higher indices, so b wins ties.
// Depends on ttaf_pkg.
module ttaf_merge import ttaf_pkg::*; #(
  parameter int VW = VALUE_WIDTH_DEF
) (
  input  cnt_t                   a_cnt,
  input  logic signed [VW-1:0]   a_v1,
  input  logic [INDEX_WIDTH-1:0] a_i1,
  input  logic signed [VW-1:0]   a_v2,
  input  logic [INDEX_WIDTH-1:0] a_i2,
  input  cnt_t                   b_cnt,
  input  logic signed [VW-1:0]   b_v1,
  input  logic [INDEX_WIDTH-1:0] b_i1,
  input  logic signed [VW-1:0]   b_v2,
  input  logic [INDEX_WIDTH-1:0] b_i2,
  output cnt_t                   y_cnt,
  output logic signed [VW-1:0]   y_v1,
  output logic [INDEX_WIDTH-1:0] y_i1,
  output logic signed [VW-1:0]   y_v2,
  output logic [INDEX_WIDTH-1:0] y_i2
);

  logic a1, a2, b1, b2, take_b;

  always_comb begin
    a1     = (a_cnt != CNT_NONE);
    a2     = (a_cnt == CNT_TWO);
    b1     = (b_cnt != CNT_NONE);
    b2     = (b_cnt == CNT_TWO);
    take_b = b1 && (!a1 || (b_v1 >= a_v1));
    if (take_b) begin
      y_v1 = b_v1;
      y_i1 = b_i1;
      if (b2 && (!a1 || (b_v2 >= a_v1))) begin
        y_v2 = b_v2;
        y_i2 = b_i2;
      end else begin
        y_v2 = a_v1;
        y_i2 = a_i1;
      end
    end else begin
      y_v1 = a_v1;
      y_i1 = a_i1;
      if (b1 && (!a2 || (b_v1 >= a_v2))) begin
        y_v2 = b_v1;
        y_i2 = b_i1;
      end else begin
        y_v2 = a_v2;
        y_i2 = a_i2;
      end
    end
    if (a2 || b2 || (a1 && b1)) begin
      y_cnt = CNT_TWO;
    end else if (a1 || b1) begin
      y_cnt = CNT_ONE;
    end else begin
      y_cnt = CNT_NONE;
    end
  end

endmodule

### rtl/top_two_argmax_finder_top.sv
// Top-two argmax finder: lanes feed a registered merge tree, then a running tracker.
// Path from an accepted last beat to result valid: leaf registers, registered tree levels, output register.
// Throughput: one beat per cycle unless stalled; a result waiting in the output register holds a last beat at the end.
// Reset (synchronous): clears stage valid bits, beat count, tracker count and output valid.
// Depends on ttaf_pkg, ttaf_lane, ttaf_merge.
module top_two_argmax_finder_top import ttaf_pkg::*; #(
  parameter int VECTOR_SIZE = VECTOR_SIZE_DEF,
  parameter int LANES       = LANES_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] value_0,
  input  logic signed [VALUE_WIDTH-1:0] value_1,
  input  logic signed [VALUE_WIDTH-1:0] value_2,
  input  logic signed [VALUE_WIDTH-1:0] value_3,
  input  logic signed [VALUE_WIDTH-1:0] value_4,
  input  logic signed [VALUE_WIDTH-1:0] value_5,
  input  logic signed [VALUE_WIDTH-1:0] value_6,
  input  logic signed [VALUE_WIDTH-1:0] value_7,
  input  logic                          last_beat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [INDEX_WIDTH-1:0]        first_index,
  output logic signed [VALUE_WIDTH-1:0] first_value,
  output logic [INDEX_WIDTH-1:0]        second_index,
  output logic signed [VALUE_WIDTH-1:0] second_value
);

  localparam int VW         = VALUE_WIDTH;
  localparam int BEAT_LIMIT = (VECTOR_SIZE + LANES - 1) / LANES;
  localparam int BEAT_W     = $clog2(BEAT_LIMIT + 1);
  localparam int D          = $clog2(LANES);
  localparam int PAD        = 1 << D;
  localparam int NN         = 2 * PAD - 1;

  logic signed [VW-1:0] port_val [PORT_LANES];

  logic [BEAT_W-1:0] beat_num;
  logic              accept;
  logic [D:0]        stage_valid;
  logic [D:0]        stage_last;
  logic [D:0]        move;
  logic              out_free;

  // heap-ordered node records: node 1 is the root, leaves are PAD..NN
  cnt_t                   nd_cnt [1:NN];
  logic signed [VW-1:0]   nd_v1  [1:NN];
  logic [INDEX_WIDTH-1:0] nd_i1  [1:NN];
  logic signed [VW-1:0]   nd_v2  [1:NN];
  logic [INDEX_WIDTH-1:0] nd_i2  [1:NN];
  cnt_t                   nx_cnt [1:NN];
  logic signed [VW-1:0]   nx_v1  [1:NN];
  logic [INDEX_WIDTH-1:0] nx_i1  [1:NN];
  logic signed [VW-1:0]   nx_v2  [1:NN];
  logic [INDEX_WIDTH-1:0] nx_i2  [1:NN];
  logic [NN:1]            nd_ld;

  cnt_t                   trk_cnt;
  logic signed [VW-1:0]   trk_v1, trk_v2;
  logic [INDEX_WIDTH-1:0] trk_i1, trk_i2;
  cnt_t                   mrg_cnt;
  logic signed [VW-1:0]   mrg_v1, mrg_v2;
  logic [INDEX_WIDTH-1:0] mrg_i1, mrg_i2;

  cnt_t                   out_cnt;
  logic signed [VW-1:0]   out_v1, out_v2;
  logic [INDEX_WIDTH-1:0] out_i1, out_i2;
  logic                   pick_runner;

  assign port_val[0] = value_0;
  assign port_val[1] = value_1;
  assign port_val[2] = value_2;
  assign port_val[3] = value_3;
  assign port_val[4] = value_4;
  assign port_val[5] = value_5;
  assign port_val[6] = value_6;
  assign port_val[7] = value_7;

  // ---- stage handshake ----
  assign out_free = !out_valid || !out_stall;
  // only a last beat needs the output register
  assign move[D]  = stage_valid[D] && (!stage_last[D] || out_free);

  genvar gd;
  generate
    for (gd = 0; gd < D; gd++) begin : g_move
      assign move[gd] = stage_valid[gd] && (!stage_valid[gd+1] || move[gd+1]);
    end
  endgenerate

  assign in_stall = stage_valid[0] && !move[0];
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (accept) begin
        stage_valid[0] <= 1'b1;
      end else if (move[0]) begin
        stage_valid[0] <= 1'b0;
      end
      for (int d = 1; d <= D; d++) begin
        if (move[d-1]) begin
          stage_valid[d] <= 1'b1;
        end else if (move[d]) begin
          stage_valid[d] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_last[0] <= last_beat;
    end
    for (int d = 1; d <= D; d++) begin
      if (move[d-1]) begin
        stage_last[d] <= stage_last[d-1];
      end
    end
  end

  // beat count saturates past the vector and restarts after the last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_num <= '0;
    end else if (accept) begin
      if (last_beat) begin
        beat_num <= '0;
      end else if (beat_num < BEAT_W'(BEAT_LIMIT)) begin
        beat_num <= beat_num + 1'b1;
      end
    end
  end

  // ---- lanes (leaves) ----
  genvar gl;
  generate
    for (gl = 0; gl < PAD; gl++) begin : g_leaf
      assign nd_ld[PAD+gl] = accept;
      if (gl < LANES) begin : g_live
        logic                   hit;
        logic [INDEX_WIDTH-1:0] index;
        ttaf_lane #(
          .VECTOR_SIZE (VECTOR_SIZE),
          .LANES       (LANES),
          .LANE        (gl)
        ) u_lane (
          .beat_num (beat_num),
          .hit      (hit),
          .index    (index)
        );
        assign nx_cnt[PAD+gl] = hit ? CNT_ONE : CNT_NONE;
        assign nx_v1[PAD+gl]  = port_val[gl];
        assign nx_i1[PAD+gl]  = index;
        assign nx_v2[PAD+gl]  = port_val[gl];
        assign nx_i2[PAD+gl]  = index;
      end else begin : g_pad
        assign nx_cnt[PAD+gl] = CNT_NONE;
        assign nx_v1[PAD+gl]  = '0;
        assign nx_i1[PAD+gl]  = '0;
        assign nx_v2[PAD+gl]  = '0;
        assign nx_i2[PAD+gl]  = '0;
      end
    end
  endgenerate

  // ---- merge tree, one registered level per stage ----
  genvar gk;
  generate
    for (gk = 1; gk < PAD; gk++) begin : g_node
      localparam int SRC = D - $clog2(gk + 1);
      assign nd_ld[gk] = move[SRC];
      ttaf_merge #(.VW(VW)) u_merge (
        .a_cnt (nd_cnt[2*gk]),   .a_v1 (nd_v1[2*gk]),   .a_i1 (nd_i1[2*gk]),
        .a_v2  (nd_v2[2*gk]),    .a_i2 (nd_i2[2*gk]),
        .b_cnt (nd_cnt[2*gk+1]), .b_v1 (nd_v1[2*gk+1]), .b_i1 (nd_i1[2*gk+1]),
        .b_v2  (nd_v2[2*gk+1]),  .b_i2 (nd_i2[2*gk+1]),
        .y_cnt (nx_cnt[gk]),     .y_v1 (nx_v1[gk]),     .y_i1 (nx_i1[gk]),
        .y_v2  (nx_v2[gk]),      .y_i2 (nx_i2[gk])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NN; k++) begin
      if (nd_ld[k]) begin
        nd_cnt[k] <= nx_cnt[k];
        nd_v1[k]  <= nx_v1[k];
        nd_i1[k]  <= nx_i1[k];
        nd_v2[k]  <= nx_v2[k];
        nd_i2[k]  <= nx_i2[k];
      end
    end
  end

  // ---- running tracker ----
  ttaf_merge #(.VW(VW)) u_track (
    .a_cnt (trk_cnt),   .a_v1 (trk_v1),   .a_i1 (trk_i1),
    .a_v2  (trk_v2),    .a_i2 (trk_i2),
    .b_cnt (nd_cnt[1]), .b_v1 (nd_v1[1]), .b_i1 (nd_i1[1]),
    .b_v2  (nd_v2[1]),  .b_i2 (nd_i2[1]),
    .y_cnt (mrg_cnt),   .y_v1 (mrg_v1),   .y_i1 (mrg_i1),
    .y_v2  (mrg_v2),    .y_i2 (mrg_i2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      trk_cnt <= CNT_NONE;
    end else if (move[D]) begin
      trk_cnt <= stage_last[D] ? CNT_NONE : mrg_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (move[D]) begin
      trk_v1 <= mrg_v1;
      trk_i1 <= mrg_i1;
      trk_v2 <= mrg_v2;
      trk_i2 <= mrg_i2;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move[D] && stage_last[D]) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move[D] && stage_last[D]) begin
      out_cnt <= mrg_cnt;
      out_v1  <= mrg_v1;
      out_i1  <= mrg_i1;
      out_v2  <= mrg_v2;
      out_i2  <= mrg_i2;
    end
  end

  // runner against a zero at the winner's index; zero tie goes to the higher index
  assign pick_runner = (out_cnt == CNT_TWO) &&
                       ((out_v2 > 0) || ((out_v2 == 0) && (out_i2 > out_i1)));

  // an empty vector reports index 0 with value 0
  assign first_index  = (out_cnt == CNT_NONE) ? '0 : out_i1;
  assign first_value  = (out_cnt == CNT_NONE) ? '0 : out_v1;
  assign second_index = pick_runner ? out_i2 : first_index;
  assign second_value = pick_runner ? out_v2 : '0;

`ifndef SYNTHESIS
  a_trk_cnt_range: assert property (@(posedge clk) disable iff (rst)
    trk_cnt != 2'd3)
    else $error("tracker count out of range");

  a_beat_sat: assert property (@(posedge clk) disable iff (rst)
    beat_num <= BEAT_W'(BEAT_LIMIT))
    else $error("beat count past limit");

  a_trk_clear: assert property (@(posedge clk) disable iff (rst)
    (move[D] && stage_last[D]) |=> (trk_cnt == CNT_NONE))
    else $error("tracker not cleared after last beat");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_cnt == CNT_TWO)) |-> (out_v1 >= out_v2))
    else $error("runner exceeds leader");
`endif

endmodule
